// File: rtl/mmm_pkg.sv
// ----------------------------------------------------------------------------
// mmm_pkg: shared types and constants for the masked matrix multiply
// Command codes, register indexes, field widths and the sequencer types.
// ----------------------------------------------------------------------------
package mmm_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;

    localparam logic [DATA_W-1:0] MASK_RESET = 32'hFFFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // one multiply-accumulate step handed to the shared unit
    typedef struct packed {
        logic issue;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// File: rtl/mmm_ram.sv
// ----------------------------------------------------------------------------
// mmm_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mmm_mac.sv
// ----------------------------------------------------------------------------
// mmm_mac: shared multiply-accumulate unit
// Multiplies the two read words, registers the low product word, then adds
// it into the running sum and applies the mask. Pulses done after the last
// step of an element.
// ----------------------------------------------------------------------------
module mmm_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mmm_pkg::t_mac_ctl         i_ctl,
    input  logic [mmm_pkg::DATA_W-1:0] i_a,
    input  logic [mmm_pkg::DATA_W-1:0] i_b,
    input  logic [mmm_pkg::DATA_W-1:0] i_mask,
    output logic [mmm_pkg::DATA_W-1:0] o_acc,
    output logic                      o_done
);

    import mmm_pkg::*;

    // stage 1 lines up with the memory read data, stage 2 with the product
    t_mac_ctl            r_ctl1;
    t_mac_ctl            r_ctl2;
    logic [DATA_W-1:0]   r_prod;
    logic [DATA_W-1:0]   r_acc;
    logic                r_done;
    logic [2*DATA_W-1:0] full_prod;
    logic [DATA_W-1:0]   n_acc;

    // only the low word survives the mask
    assign full_prod = i_a * i_b;
    assign n_acc     = (r_prod + (r_ctl2.first ? '0 : r_acc)) & i_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.issue & r_ctl2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl1.issue) begin
            r_prod <= full_prod[DATA_W-1:0];
        end
        if (r_ctl2.issue) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// File: rtl/masked_matrix_multiply.sv
// ----------------------------------------------------------------------------
// masked_matrix_multiply: masked square matrix multiply, mod 2^32 results
// Loads fill A and B one element per request; a start request computes
// C = A x B with the mask applied after every accumulation step.
// ----------------------------------------------------------------------------
// Load: accepted back to back while no start is running, no result.
// Start: each result takes n steps through the one shared multiplier, then
//   drains through the read, multiply and add registers and is emitted;
//   input is stalled until the last result is in the output register.
//   Output stalls hold the sequencer until the output register is free.
// Reset: synchronous, active low; mask and size return to all ones and 8.
//   Matrix contents are not cleared.
module masked_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mmm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mmm_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mmm_pkg::CMD_W-1:0]       i_cmd,
    input  logic [mmm_pkg::IDX_W-1:0]       i_row,
    input  logic [mmm_pkg::IDX_W-1:0]       i_col,
    input  logic [mmm_pkg::DATA_W-1:0]      i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mmm_pkg::IDX_W-1:0]       o_out_row,
    output logic [mmm_pkg::IDX_W-1:0]       o_out_col,
    output logic [mmm_pkg::DATA_W-1:0]      o_out_value,
    output logic                            o_last
);

    import mmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [AW-1:0]     DimA = AW'(MAX_DIM);
    localparam logic [SIZE_W-1:0] DimS = SIZE_W'(MAX_DIM);

    t_state              r_state, n_state;
    logic [DW-1:0]       r_i, n_i;
    logic [DW-1:0]       r_j, n_j;
    logic [DW-1:0]       r_k, n_k;
    logic [DW-1:0]       r_last_idx, n_last_idx;
    logic [DATA_W-1:0]   r_mask;
    logic [SIZE_W-1:0]   r_size;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_row;
    logic [IDX_W-1:0]    r_out_col;
    logic [DATA_W-1:0]   r_out_value;
    logic                r_out_last;

    logic                in_accept;
    logic                out_accept;
    logic                load_out;
    logic                in_range;
    logic [SIZE_W-1:0]   eff_size;
    t_mac_ctl            mac_ctl;
    logic [DATA_W-1:0]   mac_acc;
    logic                mac_done;
    logic                we_a, we_b;
    logic [AW-1:0]       waddr, raddr_a, raddr_b;
    logic [DATA_W-1:0]   rdata_a, rdata_b;

    assign in_accept  = i_in_valid & ~o_in_stall;
    assign out_accept = r_out_valid & ~i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // size 0 runs as 1, oversize saturates
    always_comb begin
        if (r_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_size > DimS) begin
            eff_size = DimS;
        end else begin
            eff_size = r_size;
        end
    end

    assign in_range = ({1'b0, i_row} < DimS) && ({1'b0, i_col} < DimS);
    assign waddr    = AW'(i_row) * DimA + AW'(i_col);
    assign we_a     = in_accept && (i_cmd == CMD_LOAD_A) && in_range;
    assign we_b     = in_accept && (i_cmd == CMD_LOAD_B) && in_range;
    assign raddr_a  = AW'(r_i) * DimA + AW'(r_k);
    assign raddr_b  = AW'(r_k) * DimA + AW'(r_j);

    mmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    mmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .i_mask  (r_mask),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_last_idx <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_last_idx <= n_last_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_last_idx = r_last_idx;
        mac_ctl    = '0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_cmd == CMD_START)) begin
                    n_state    = ST_ISSUE;
                    n_i        = '0;
                    n_j        = '0;
                    n_k        = '0;
                    n_last_idx = DW'(eff_size - SIZE_W'(1));
                end
            end
            ST_ISSUE: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.first = (r_k == '0);
                mac_ctl.last  = (r_k == r_last_idx);
                if (r_k == r_last_idx) begin
                    n_k     = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + DW'(1);
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    if (r_j == r_last_idx) begin
                        n_j = '0;
                        if (r_i == r_last_idx) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_i     = r_i + DW'(1);
                            n_state = ST_ISSUE;
                        end
                    end else begin
                        n_j     = r_j + DW'(1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MASK: r_mask <= i_cfg_data;
                REG_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // output register: refilled in the cycle the old result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_row   <= IDX_W'(r_i);
            r_out_col   <= IDX_W'(r_j);
            r_out_value <= mac_acc;
            r_out_last  <= (r_i == r_last_idx) && (r_j == r_last_idx);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

endmodule

// File: rtl/mmm_checker.sv
// ----------------------------------------------------------------------------
// mmm_checker: port-level checks for the masked matrix multiply
// Watches the request channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module mmm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [mmm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [mmm_pkg::DATA_W-1:0]      i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic [mmm_pkg::CMD_W-1:0]       i_cmd,
    input logic [mmm_pkg::IDX_W-1:0]       i_row,
    input logic [mmm_pkg::IDX_W-1:0]       i_col,
    input logic [mmm_pkg::DATA_W-1:0]      i_value,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [mmm_pkg::IDX_W-1:0]       o_out_row,
    input logic [mmm_pkg::IDX_W-1:0]       o_out_col,
    input logic [mmm_pkg::DATA_W-1:0]      o_out_value,
    input logic                            o_last
);

    import mmm_pkg::*;

    logic in_accept;
    logic is_load;

    assign in_accept = i_in_valid & ~o_in_stall;
    assign is_load   = (i_cmd == CMD_LOAD_A) || (i_cmd == CMD_LOAD_B);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_out_row) && $stable(o_out_col)
             && $stable(o_out_value) && $stable(o_last)))
        else $error("result payload changed while stalled");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_cmd == CMD_START)) |=> o_in_stall)
        else $error("start request did not make the block busy");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_load && !o_out_valid) |=> !o_out_valid)
        else $error("load request produced a result");

endmodule

bind masked_matrix_multiply mmm_checker u_mmm_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for masked_matrix_multiply
// Loads A and B, starts multiplies under a range of mask and size settings,
// predicts every C element in the bench and checks each result as it leaves
// the block, with random gaps on the request side and random output stalls.
// ----------------------------------------------------------------------------
module testbench;

    import mmm_pkg::*;

    localparam int DIM           = 8;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_product;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_cmd;
    logic [IDX_W-1:0]     i_row;
    logic [IDX_W-1:0]     i_col;
    logic [DATA_W-1:0]    i_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [IDX_W-1:0]     o_out_row;
    logic [IDX_W-1:0]     o_out_col;
    logic [DATA_W-1:0]    o_out_value;
    logic                 o_last;

    // bench copy of the block state
    logic [DATA_W-1:0] left_store  [DIM*DIM];
    logic [DATA_W-1:0] right_store [DIM*DIM];
    bit                left_written  [DIM*DIM];
    bit                right_written [DIM*DIM];
    logic [DATA_W-1:0] model_mask;
    logic [SIZE_W-1:0] model_size;

    t_product expected_products[$];
    t_product oldest_product;
    int       error_count;
    int       send_idle_pct;
    int       recv_stall_pct;

    masked_matrix_multiply #(
        .MAX_DIM (DIM)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic int active_size();
        int n;
        n = model_size;
        if (n < 1) n = 1;
        if (n > DIM) n = DIM;
        return n;
    endfunction

    // C = A x B, mask applied after every multiply-accumulate step
    function automatic void multiply_matrices();
        int                n;
        logic [63:0]       sum;
        logic [DATA_W-1:0] acc;
        t_product          p;
        n = active_size();
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++) begin
                    sum = 64'(left_store[i*DIM+k]) * 64'(right_store[k*DIM+j]) + 64'(acc);
                    acc = sum[DATA_W-1:0] & model_mask;
                end
                p.row   = IDX_W'(i);
                p.col   = IDX_W'(j);
                p.value = acc;
                p.last  = (i == n - 1) && (j == n - 1);
                expected_products.push_back(p);
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return DATA_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] expected_value,
                                   input logic [DATA_W-1:0] actual_value);
        error_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field,
                 expected_value, actual_value);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_products.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none actual row %0d col %0d value %h last %b",
                         $time, o_out_row, o_out_col, o_out_value, o_last);
            end else begin
                oldest_product = expected_products.pop_front();
                if (o_out_row !== oldest_product.row)
                    report_mismatch("out_row", DATA_W'(oldest_product.row), DATA_W'(o_out_row));
                if (o_out_col !== oldest_product.col)
                    report_mismatch("out_col", DATA_W'(oldest_product.col), DATA_W'(o_out_col));
                if (o_out_value !== oldest_product.value)
                    report_mismatch("out_value", oldest_product.value, o_out_value);
                if (o_last !== oldest_product.last)
                    report_mismatch("last", DATA_W'(oldest_product.last), DATA_W'(o_last));
            end
        end
    end

    // one request; valid stays up across back-to-back requests
    task automatic send_request(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                input logic [DATA_W-1:0] value);
        int addr;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_row      <= IDX_W'(row);
        i_col      <= IDX_W'(col);
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        addr = row * DIM + col;
        case (cmd)
            CMD_LOAD_A: begin
                left_store[addr]   = value;
                left_written[addr] = 1'b1;
            end
            CMD_LOAD_B: begin
                right_store[addr]   = value;
                right_written[addr] = 1'b1;
            end
            CMD_START: multiply_matrices();
            default: ;
        endcase
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            REG_MASK: model_mask = data;
            REG_SIZE: model_size = data[SIZE_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all results, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_loads_and_extremes();
        wait_idle();
        write_register(REG_MASK, MASK_RESET);
        write_register(REG_SIZE, 4'd2);
        send_request(CMD_LOAD_A, 0, 0, 32'hFFFF_FFFF);
        send_request(CMD_LOAD_A, 0, 1, 32'hFFFF_FFFF);
        send_request(CMD_LOAD_A, 1, 0, 32'h0000_0000);
        send_request(CMD_LOAD_A, 1, 1, 32'h0000_0001);
        send_request(CMD_LOAD_B, 0, 0, 32'hFFFF_FFFF);
        send_request(CMD_LOAD_B, 0, 1, 32'hFFFF_FFFF);
        send_request(CMD_LOAD_B, 1, 0, 32'h0000_0007);
        send_request(CMD_LOAD_B, 1, 1, 32'h0000_0000);
        // unused command must not touch A[0][0]
        send_request(CMD_UNUSED, 0, 0, 32'h1234_5678);
        send_request(CMD_START, 7, 7, 32'hFFFF_FFFF);
        send_request(CMD_LOAD_A, 7, 7, 32'hFFFF_FFFF);
        send_request(CMD_LOAD_B, 7, 7, 32'h8000_0001);
        send_request(CMD_LOAD_A, 5, 2, 32'hAAAA_5555);
    endtask

    task automatic test_register_settings();
        wait_idle();
        write_register(REG_SIZE, 4'd0);     // zero size acts as one
        send_request(CMD_START, 0, 0, 32'h0);
        wait_idle();
        write_register(REG_MASK, 32'h0);
        write_register(REG_SIZE, 4'd2);
        send_request(CMD_START, 0, 0, 32'h0);
        wait_idle();
        write_register(REG_MASK, 32'h0000_FFFF);
        send_request(CMD_START, 0, 0, 32'h0);
        wait_idle();
        // spare indexes change nothing
        write_register(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_register(REG_SPARE_HI, 32'h0000_0001);
        send_request(CMD_START, 0, 0, 32'h0);
    endtask

    task automatic run_segment(input logic [DATA_W-1:0] mask, input logic [SIZE_W-1:0] size,
                               input int count);
        int pick;
        int n;
        logic [CMD_W-1:0] cmd;
        wait_idle();
        write_register(REG_MASK, mask);
        write_register(REG_SIZE, size);
        n = active_size();
        for (int item = 0; item < count; item++) begin
            pick = $urandom_range(0, 99);
            if (pick < 9) begin
                // every element the start will read must be written first
                for (int r = 0; r < n; r++) begin
                    for (int c = 0; c < n; c++) begin
                        if (!left_written[r*DIM+c])
                            send_request(CMD_LOAD_A, r, c, rand_word());
                        if (!right_written[r*DIM+c])
                            send_request(CMD_LOAD_B, r, c, rand_word());
                    end
                end
                send_request(CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
            end else if (pick < 12) begin
                send_request(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
                send_request(cmd,
                             ($urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                         : $urandom_range(0, 7),
                             ($urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                         : $urandom_range(0, 7),
                             rand_word());
            end
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input logic [DATA_W-1:0] mask_a,
                                       input logic [SIZE_W-1:0] size_a,
                                       input logic [DATA_W-1:0] mask_b,
                                       input logic [SIZE_W-1:0] size_b);
        wait_idle();
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        run_segment(mask_a, size_a, 31);
        run_segment(mask_b, size_b, 31);
    endtask

    initial begin
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        model_mask     = MASK_RESET;
        model_size     = SIZE_RESET;
        for (int a = 0; a < DIM*DIM; a++) begin
            left_store[a]    = '0;
            right_store[a]   = '0;
            left_written[a]  = 1'b0;
            right_written[a] = 1'b0;
        end
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_LOAD_A;
        i_row       <= '0;
        i_col       <= '0;
        i_value     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_loads_and_extremes();
        test_register_settings();
        test_random_traffic(0, 0, 32'hFFFF_FFFF, 4'd8, 32'h0000_FFFF, 4'd3);
        test_random_traffic(45, 0, $urandom, 4'd15, 32'hFFFF_FFFF, 4'd1);
        test_random_traffic(0, 45, 32'h0, 4'd4, $urandom, 4'd2);
        test_random_traffic(14, 14, $urandom, SIZE_W'($urandom_range(1, 5)),
                            32'hFFFF_FFFF, 4'd0);

        wait_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
